// File: design/length_prefixed_line_deframer_macros.svh
// assertion macros shared by the deframer modules
// expects signals named clock and reset in the using module
`ifndef LENGTH_PREFIXED_LINE_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_LINE_DEFRAMER_MACROS_SVH

// checked outside reset
`define LPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset too
`define LPD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/lpd_pkg.sv
// shared types, constants and helpers of the line deframer
// no dependencies
package lpd_pkg;

   localparam int HEADER_MAX_DEF  = 32;
   localparam int COUNT_WIDTH_DEF = 24;
   localparam int MAGIC_LEN       = 7;
   localparam int IDX_W           = 6;
   localparam int CNT_W           = 7;
   localparam int QDEPTH          = 4;
   localparam int MAXBUF_W        = 24;
   localparam logic [MAXBUF_W-1:0] MAXBUF_RESET = 24'd1048576;

   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;

   localparam logic [7:0] MAGIC_TEXT [MAGIC_LEN] = '{8'h4D, 8'h43, 8'h48, 8'h41, 8'h54,
                                                    8'h31, 8'h20};

   localparam logic [1:0] KIND_TEXT    = 2'd0;
   localparam logic [1:0] KIND_FRAME   = 2'd1;
   localparam logic [1:0] KIND_BADHDR  = 2'd2;
   localparam logic [1:0] KIND_OVERRUN = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       end_mark;
      logic       drop;
   } item_type;

   // at most one command per accepted word: store write, store dump, then up to three results
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [7:0]       wr_data;
      logic [CNT_W-1:0] dump_cnt;
      logic [1:0]       dump_kind;
      logic [1:0]       n_emit;
      item_type [2:0]   items;
   } cmd_type;

   function automatic logic is_ws(logic [7:0] b);
      return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic cmd_type put_item(cmd_type c, logic [7:0] d, logic [1:0] kd,
                                        logic e, logic dr);
      cmd_type r;
      item_type it;
      r = c;
      it.data = d;
      it.kind = kd;
      it.end_mark = e;
      it.drop = dr;
      case (c.n_emit)
         2'd0: r.items[0] = it;
         2'd1: r.items[1] = it;
         2'd2: r.items[2] = it;
         default: r.items[2] = it;
      endcase
      r.n_emit = c.n_emit + 2'd1;
      return r;
   endfunction

endpackage

// File: design/length_prefixed_line_deframer.sv
// length-prefixed line deframer top level
// depends on lpd_pkg, lpd_front, lpd_queue, lpd_back
//
// input: one received byte per word, taken when req_push is high and req_full is low.
// output: a queue view; while rsp_empty is low the oldest result is on the rsp_ ports,
//    and rsp_pop takes it. byte words carry the open message's kind; an end word
//    (rsp_end_mark) closes the message, with rsp_drop_msg for whitespace-only ones.
//    rsp_last marks the final result caused by one input byte.
// config: csr_wr_en writes csr_max_buffered, the largest frame length and the
//    longest line; write it only while the block is idle.
// throughput: one byte per cycle for text and payload while req_full stays low; a word
//    yielding several results emits them one at a time in the output stage, and a
//    header dump first reads the stored bytes out of the header store one by one.
// a result passes the command queue and the output register; a dump adds the store read.
// a four-entry command queue lets the parser run ahead of the output stage;
//    req_full rises when it fills, so a stalled receiver back-pressures the input.
// reset: synchronous; clears queue, output and parse state; max_buffered returns
//    to 1048576. the header store needs no clearing.
module length_prefixed_line_deframer import lpd_pkg::*; #(
   parameter int HEADER_MAX  = HEADER_MAX_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_rx_byte,
   output logic                req_full,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_out_byte,
   output logic [1:0]          rsp_msg_kind,
   output logic                rsp_end_mark,
   output logic                rsp_drop_msg,
   output logic                rsp_last,
   input  logic                csr_wr_en,
   input  logic [MAXBUF_W-1:0] csr_max_buffered
);
   logic    q_full, q_push, q_pop, q_empty;
   cmd_type q_cmd, q_head;

   lpd_front #(.HEADER_MAX(HEADER_MAX), .COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_rx_byte      (req_rx_byte),
      .req_full         (req_full),
      .csr_wr_en        (csr_wr_en),
      .csr_max_buffered (csr_max_buffered),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_cmd)
   );

   lpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   lpd_back #(.HEADER_MAX(HEADER_MAX)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .head         (q_head),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_msg_kind (rsp_msg_kind),
      .rsp_end_mark (rsp_end_mark),
      .rsp_drop_msg (rsp_drop_msg),
      .rsp_last     (rsp_last)
   );
endmodule

// File: design/lpd_ram.sv
// generic single write port ram with registered read
// no dependencies
module lpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 39
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/lpd_queue.sv
// command queue between parser front and output back
// depends on lpd_pkg
module lpd_queue import lpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);
   localparam int PW = $clog2(QDEPTH);

   cmd_type         mem_ff [QDEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]     cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PW+1)'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

// File: design/lpd_front.sv
// parser front: classifies each received word and issues at most one command for it
// depends on lpd_pkg
module lpd_front import lpd_pkg::*; #(
   parameter int HEADER_MAX  = HEADER_MAX_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_rx_byte,
   output logic                req_full,
   input  logic                csr_wr_en,
   input  logic [MAXBUF_W-1:0] csr_max_buffered,
   input  logic                q_full,
   output logic                q_push,
   output cmd_type             q_cmd
);
   localparam int CW = COUNT_WIDTH;
   localparam logic [CNT_W-1:0] STORE_DEPTH = CNT_W'(MAGIC_LEN + HEADER_MAX);
   localparam logic [CNT_W-1:0] MLEN = CNT_W'(MAGIC_LEN);
   localparam logic [CW-1:0] CNT_MAX = '1;

   localparam logic [2:0] M_MAGIC   = 3'd0;
   localparam logic [2:0] M_HEADER  = 3'd1;
   localparam logic [2:0] M_TEXT    = 3'd2;
   localparam logic [2:0] M_RAWLONG = 3'd3;
   localparam logic [2:0] M_PAYLOAD = 3'd4;
   localparam logic [2:0] M_POST    = 3'd5;
   localparam logic [2:0] M_POSTCR  = 3'd6;

   localparam logic [2:0] PH_LEAD   = 3'd0;
   localparam logic [2:0] PH_SIGNP  = 3'd1;
   localparam logic [2:0] PH_SIGNN  = 3'd2;
   localparam logic [2:0] PH_DIGP   = 3'd3;
   localparam logic [2:0] PH_DIGN   = 3'd4;
   localparam logic [2:0] PH_TRAILP = 3'd5;
   localparam logic [2:0] PH_TRAILN = 3'd6;
   localparam logic [2:0] PH_BAD    = 3'd7;

   typedef struct packed {
      logic [2:0]    ph;
      logic [CW-1:0] acc;
   } len_type;

   function automatic len_type phase_step(len_type s, logic [7:0] b);
      len_type r;
      logic dig;
      logic [3:0] d;
      logic [CW+3:0] wide;
      r = s;
      dig = (b >= 8'h30) && (b <= 8'h39);
      d = 4'(b - 8'h30);
      wide = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + (CW+4)'(d);
      case (s.ph)
         PH_LEAD: begin
            if (!is_ws(b)) begin
               if (b == 8'h2B) r.ph = PH_SIGNP;
               else if (b == 8'h2D) r.ph = PH_SIGNN;
               else if (dig) begin
                  r.ph = PH_DIGP;
                  r.acc = CW'(d);
               end else r.ph = PH_BAD;
            end
         end
         PH_SIGNP, PH_SIGNN: begin
            if (dig) begin
               r.ph = (s.ph == PH_SIGNP) ? PH_DIGP : PH_DIGN;
               r.acc = CW'(d);
            end else r.ph = PH_BAD;
         end
         PH_DIGP, PH_DIGN: begin
            if (dig) begin
               if (wide[CW+3:CW] != 4'd0) begin
                  r.ph = PH_BAD;
                  r.acc = '0;
               end else r.acc = wide[CW-1:0];
            end else if (is_ws(b)) begin
               r.ph = (s.ph == PH_DIGP) ? PH_TRAILP : PH_TRAILN;
            end else r.ph = PH_BAD;
         end
         PH_TRAILP, PH_TRAILN: begin
            if (!is_ws(b)) r.ph = PH_BAD;
         end
         default: r.ph = PH_BAD;
      endcase
      return r;
   endfunction

   logic [2:0]          mode_ff, mode_in;
   logic [CNT_W-1:0]    hc_ff, hc_in;
   len_type             len_ff, len_in;
   logic [CW-1:0]       pl_ff, pl_in;
   logic [CW-1:0]       lc_ff, lc_in;
   logic                pcr_ff, pcr_in;
   logic                nb_ff, nb_in;
   logic [7:0]          lastb_ff, lastb_in;
   logic [MAXBUF_W-1:0] max_ff;
   logic                accept;

   always_comb begin
      logic [7:0]       b;
      logic [CNT_W-1:0] k;
      logic             do_magic, do_line, pos, neg, ok;
      logic [1:0]       lkind;
      cmd_type          c;
      mode_in  = mode_ff;
      hc_in    = hc_ff;
      len_in   = len_ff;
      pl_in    = pl_ff;
      lc_in    = lc_ff;
      pcr_in   = pcr_ff;
      nb_in    = nb_ff;
      lastb_in = lastb_ff;
      b        = req_rx_byte;
      c        = '0;
      k        = hc_ff;
      do_magic = 1'b0;
      do_line  = 1'b0;
      lkind    = KIND_TEXT;
      pos      = 1'b0;
      neg      = 1'b0;
      ok       = 1'b0;
      case (mode_ff)
         M_HEADER: begin
            if (k >= STORE_DEPTH) k = STORE_DEPTH - 1'b1;
            if (b == CH_LF) begin
               pos = (len_ff.ph == PH_DIGP) || (len_ff.ph == PH_TRAILP);
               neg = (len_ff.ph == PH_DIGN) || (len_ff.ph == PH_TRAILN);
               ok = (pos || (neg && len_ff.acc == '0))
                    && (32'(len_ff.acc) <= 32'(max_ff));
               if (ok) begin
                  pl_in  = len_ff.acc;
                  hc_in  = '0;
                  lc_in  = '0;
                  nb_in  = 1'b0;
                  pcr_in = 1'b0;
                  if (len_ff.acc == '0) begin
                     c = put_item(c, 8'd0, KIND_FRAME, 1'b1, 1'b1);
                     mode_in = M_POST;
                  end else begin
                     mode_in = M_PAYLOAD;
                  end
               end else begin
                  if (k != '0 && lastb_ff == CH_CR) k = k - 1'b1;
                  c.dump_cnt  = k;
                  c.dump_kind = KIND_BADHDR;
                  c = put_item(c, 8'd0, KIND_BADHDR, 1'b1, 1'b0);
                  mode_in = M_MAGIC;
                  hc_in   = '0;
                  lc_in   = '0;
                  pcr_in  = 1'b0;
                  nb_in   = 1'b0;
               end
            end else begin
               len_in    = phase_step(len_ff, b);
               c.wr_en   = 1'b1;
               c.wr_idx  = k[IDX_W-1:0];
               c.wr_data = b;
               lastb_in  = b;
               k = k + 1'b1;
               hc_in = k;
               if (lc_in != CNT_MAX) lc_in = lc_in + 1'b1;
               if (k >= STORE_DEPTH) begin
                  c.dump_cnt  = k - 1'b1;
                  c.dump_kind = KIND_BADHDR;
                  if (b == CH_CR) pcr_in = 1'b1;
                  else c = put_item(c, b, KIND_BADHDR, 1'b0, 1'b0);
                  mode_in = M_RAWLONG;
                  hc_in   = '0;
                  if (32'(lc_in) > 32'(max_ff)) begin
                     if (pcr_in) c = put_item(c, CH_CR, KIND_OVERRUN, 1'b0, 1'b0);
                     c = put_item(c, 8'd0, KIND_OVERRUN, 1'b1, 1'b0);
                     mode_in = M_MAGIC;
                     hc_in   = '0;
                     lc_in   = '0;
                     pcr_in  = 1'b0;
                     nb_in   = 1'b0;
                  end
               end else if (32'(lc_in) > 32'(max_ff)) begin
                  c.dump_cnt  = k;
                  c.dump_kind = KIND_OVERRUN;
                  c = put_item(c, 8'd0, KIND_OVERRUN, 1'b1, 1'b0);
                  mode_in = M_MAGIC;
                  hc_in   = '0;
                  lc_in   = '0;
                  pcr_in  = 1'b0;
                  nb_in   = 1'b0;
               end
            end
         end
         M_TEXT: begin
            do_line = 1'b1;
            lkind = KIND_TEXT;
         end
         M_RAWLONG: begin
            do_line = 1'b1;
            lkind = KIND_BADHDR;
         end
         M_PAYLOAD: begin
            c = put_item(c, b, KIND_FRAME, 1'b0, 1'b0);
            if (!is_ws(b)) nb_in = 1'b1;
            if (pl_in != '0) pl_in = pl_in - 1'b1;
            if (pl_in == '0) begin
               c = put_item(c, 8'd0, KIND_FRAME, 1'b1, !nb_in);
               nb_in   = 1'b0;
               mode_in = M_POST;
            end
         end
         M_POST: begin
            if (b == CH_CR) begin
               mode_in = M_POSTCR;
            end else begin
               mode_in = M_MAGIC;
               hc_in   = '0;
               lc_in   = '0;
               pcr_in  = 1'b0;
               nb_in   = 1'b0;
               do_magic = (b != CH_LF);
            end
         end
         M_POSTCR: begin
            mode_in = M_MAGIC;
            hc_in   = '0;
            lc_in   = '0;
            pcr_in  = 1'b0;
            nb_in   = 1'b0;
            if (b != CH_LF) begin
               mode_in = M_TEXT;
               pcr_in  = 1'b1;
               lc_in   = CW'(1);
               do_line = 1'b1;
            end
         end
         M_MAGIC: begin
            do_magic = 1'b1;
         end
         default: begin
            mode_in  = M_MAGIC;
            hc_in    = '0;
            lc_in    = '0;
            pcr_in   = 1'b0;
            nb_in    = 1'b0;
            do_magic = 1'b1;
         end
      endcase

      if (do_magic) begin
         k = hc_in;
         if (k < MLEN && b == MAGIC_TEXT[k[2:0]]) begin
            c.wr_en   = 1'b1;
            c.wr_idx  = k[IDX_W-1:0];
            c.wr_data = b;
            lastb_in  = b;
            hc_in = k + 1'b1;
            lc_in = CW'(hc_in);
            if (hc_in == MLEN) begin
               mode_in = M_HEADER;
               len_in.ph  = PH_LEAD;
               len_in.acc = '0;
            end
            if (32'(lc_in) > 32'(max_ff)) begin
               c.dump_cnt  = hc_in;
               c.dump_kind = KIND_OVERRUN;
               c = put_item(c, 8'd0, KIND_OVERRUN, 1'b1, 1'b0);
               mode_in = M_MAGIC;
               hc_in   = '0;
               lc_in   = '0;
               pcr_in  = 1'b0;
               nb_in   = 1'b0;
            end
         end else begin
            if (k > MLEN) k = '0;
            c.dump_cnt  = k;
            c.dump_kind = KIND_TEXT;
            mode_in = M_TEXT;
            hc_in   = '0;
            lc_in   = CW'(k);
            pcr_in  = 1'b0;
            nb_in   = (k != '0);
            do_line = 1'b1;
            lkind   = KIND_TEXT;
         end
      end

      if (do_line) begin
         if (b == CH_LF) begin
            c = put_item(c, 8'd0, lkind, 1'b1, (lkind == KIND_TEXT) ? !nb_in : 1'b0);
            mode_in = M_MAGIC;
            hc_in   = '0;
            lc_in   = '0;
            pcr_in  = 1'b0;
            nb_in   = 1'b0;
         end else begin
            if (pcr_in) begin
               c = put_item(c, CH_CR, lkind, 1'b0, 1'b0);
               pcr_in = 1'b0;
            end
            if (b == CH_CR) begin
               pcr_in = 1'b1;
            end else begin
               c = put_item(c, b, lkind, 1'b0, 1'b0);
               if (!is_ws(b)) nb_in = 1'b1;
            end
            if (lc_in != CNT_MAX) lc_in = lc_in + 1'b1;
            if (32'(lc_in) > 32'(max_ff)) begin
               if (pcr_in) c = put_item(c, CH_CR, KIND_OVERRUN, 1'b0, 1'b0);
               c = put_item(c, 8'd0, KIND_OVERRUN, 1'b1, 1'b0);
               mode_in = M_MAGIC;
               hc_in   = '0;
               lc_in   = '0;
               pcr_in  = 1'b0;
               nb_in   = 1'b0;
            end
         end
      end
      q_cmd = c;
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept && (q_cmd.wr_en || q_cmd.dump_cnt != '0 || q_cmd.n_emit != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= M_MAGIC;
         hc_ff      <= '0;
         len_ff.ph  <= PH_LEAD;
         len_ff.acc <= '0;
         pl_ff      <= '0;
         lc_ff      <= '0;
         pcr_ff     <= 1'b0;
         nb_ff      <= 1'b0;
         max_ff     <= MAXBUF_RESET;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            hc_ff   <= hc_in;
            len_ff  <= len_in;
            pl_ff   <= pl_in;
            lc_ff   <= lc_in;
            pcr_ff  <= pcr_in;
            nb_ff   <= nb_in;
         end
         if (csr_wr_en) begin
            max_ff <= csr_max_buffered;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lastb_ff <= lastb_in;
      end
   end
endmodule

// File: design/lpd_back.sv
// output back: runs queued commands, owns the header store, drives the result port
// depends on lpd_pkg, lpd_ram and the assertion macro header
`include "length_prefixed_line_deframer_macros.svh"
module lpd_back import lpd_pkg::*; #(
   parameter int HEADER_MAX = HEADER_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    head,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_msg_kind,
   output logic       rsp_end_mark,
   output logic       rsp_drop_msg,
   output logic       rsp_last
);
   localparam int DEPTH = MAGIC_LEN + HEADER_MAX;
   localparam int AW = $clog2(DEPTH);

   localparam logic [1:0] ST_START = 2'd0;
   localparam logic [1:0] ST_RD    = 2'd1;
   localparam logic [1:0] ST_DV    = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       stage_ff, stage_in;
   logic [CNT_W-1:0] di_ff, di_in;
   logic [1:0]       ei_ff, ei_in;
   logic [1:0]       ei_eff;
   logic             ram_re;
   logic [CNT_W-1:0] ram_ridx;
   logic [7:0]       ram_rdata;
   logic             out_free, emit, elast, do_items;
   item_type         eit;
   item_type         out_ff;
   logic             out_last_ff, out_valid_ff;

   lpd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (!q_empty && stage_ff == ST_START && head.wr_en),
      .wr_addr (head.wr_idx[AW-1:0]),
      .wr_data (head.wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_ridx[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign out_free = !out_valid_ff || rsp_pop;
   assign ei_eff   = (stage_ff == ST_START) ? 2'd0 : ei_ff;
   assign do_items = (stage_ff == ST_EMIT)
                     || (stage_ff == ST_START && head.dump_cnt == '0 && head.n_emit != 2'd0);

   always_comb begin
      q_pop    = 1'b0;
      ram_re   = 1'b0;
      ram_ridx = di_ff;
      emit     = 1'b0;
      elast    = 1'b0;
      eit      = '0;
      stage_in = stage_ff;
      di_in    = di_ff;
      ei_in    = ei_ff;
      if (!q_empty) begin
         case (stage_ff)
            ST_START: begin
               if (head.dump_cnt != '0) begin
                  stage_in = ST_RD;
                  di_in    = '0;
               end else if (head.n_emit == 2'd0) begin
                  q_pop = 1'b1;
               end
            end
            ST_RD: begin
               ram_re   = 1'b1;
               stage_in = ST_DV;
            end
            ST_DV: begin
               if (out_free) begin
                  emit = 1'b1;
                  eit.data = ram_rdata;
                  eit.kind = head.dump_kind;
                  if (di_ff + 1'b1 < head.dump_cnt) begin
                     ram_re   = 1'b1;
                     ram_ridx = di_ff + 1'b1;
                     di_in    = di_ff + 1'b1;
                  end else if (head.n_emit == 2'd0) begin
                     elast    = 1'b1;
                     q_pop    = 1'b1;
                     stage_in = ST_START;
                  end else begin
                     stage_in = ST_EMIT;
                     ei_in    = 2'd0;
                  end
               end
            end
            default: ;
         endcase
         if (do_items && out_free) begin
            emit  = 1'b1;
            eit   = head.items[ei_eff];
            elast = (ei_eff == head.n_emit - 2'd1);
            if (elast) begin
               q_pop    = 1'b1;
               stage_in = ST_START;
            end else begin
               ei_in    = ei_eff + 2'd1;
               stage_in = ST_EMIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= ST_START;
         di_ff        <= '0;
         ei_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         di_ff    <= di_in;
         ei_ff    <= ei_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff      <= eit;
         out_last_ff <= elast;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = out_ff.data;
   assign rsp_msg_kind = out_ff.kind;
   assign rsp_end_mark = out_ff.end_mark;
   assign rsp_drop_msg = out_ff.drop;
   assign rsp_last     = out_last_ff;

   `LPD_ASSERT(a_dump_in_range, (stage_ff == ST_DV) |-> (di_ff < head.dump_cnt), "dump index past count")
   `LPD_ASSERT(a_busy_has_cmd, (stage_ff != ST_START) |-> !q_empty, "back busy with no command")
   `LPD_ASSERT_ALWAYS(a_reset_idle, reset |=> (stage_ff == ST_START && !out_valid_ff), "not idle after reset")
endmodule
